[sv/eulrot_pkg.sv]
// Shared constants, mode codes and the sine table generator for the Euler rotation matrix block.
package eulrot_pkg;

    localparam int ANGLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 12;

    localparam logic [1:0] FUNC_ZXY_NEG = 2'd0;
    localparam logic [1:0] FUNC_XYZ     = 2'd1;
    localparam logic [1:0] FUNC_ZXY     = 2'd2;
    localparam logic [1:0] FUNC_Z_ONLY  = 2'd3;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave entry k: sin(pi/2 * k / 2^(angle_bits-2)) with frac_bits fraction bits.
    // The odd Taylor series runs to the x^25 term; each step divides by (2n)(2n+1).
    function automatic longint unsigned f_quarter_sine(input longint unsigned k,
                                                       input int unsigned angle_bits,
                                                       input int unsigned frac_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (HALF_PI_Q30 * k + (64'd1 << (angle_bits - 3))) >> (angle_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd342;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd420;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd506;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd600;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        sum = $signed(($unsigned(sum) + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits));
        if (sum > $signed(64'd1 << frac_bits)) begin
            sum = $signed(64'd1 << frac_bits);
        end
        return $unsigned(sum);
    endfunction

endpackage

[sv/eulrot_in_if.sv]
// Request channel carrying the mode and the three angles.
interface eulrot_in_if #(
    parameter int ANGLE_BITS = eulrot_pkg::ANGLE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            func;
    logic [ANGLE_BITS-1:0] angle_x;
    logic [ANGLE_BITS-1:0] angle_y;
    logic [ANGLE_BITS-1:0] angle_z;

    modport source (output valid, func, angle_x, angle_y, angle_z, input ready);
    modport sink   (input valid, func, angle_x, angle_y, angle_z, output ready);
endinterface

[sv/eulrot_out_if.sv]
// Result channel carrying the nine rotation matrix entries.
interface eulrot_out_if #(
    parameter int FRAC_BITS = eulrot_pkg::FRAC_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [FRAC_BITS+1:0] m00;
    logic signed [FRAC_BITS+1:0] m01;
    logic signed [FRAC_BITS+1:0] m02;
    logic signed [FRAC_BITS+1:0] m10;
    logic signed [FRAC_BITS+1:0] m11;
    logic signed [FRAC_BITS+1:0] m12;
    logic signed [FRAC_BITS+1:0] m20;
    logic signed [FRAC_BITS+1:0] m21;
    logic signed [FRAC_BITS+1:0] m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

[sv/euler_rotation_matrix_q12.sv]
// Top level of the Euler-angle rotation matrix generator.
// Each request carries three angles (one turn is 2^ANGLE_BITS) and a mode, and yields one
// 3x3 rotation matrix in signed fixed point with FRAC_BITS fraction bits, saturated to
// +/-1.0. The pipeline takes one request per cycle while the output is not stalled, in four
// registered stages: the three dual-port sine ROMs, the pairwise products, the triple
// products, and the sums and saturation. Every stage holds its item while the next one is
// full, so the block keeps accepting requests until all four stages are occupied.
module euler_rotation_matrix_q12 #(
    parameter int ANGLE_BITS = eulrot_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = eulrot_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    eulrot_in_if.sink    i_req,
    eulrot_out_if.source o_mat
);
    localparam int W     = FRAC_BITS + 2;
    localparam int AW    = ANGLE_BITS - 1;
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int QSIZE = 1 << (ANGLE_BITS - 2);

    typedef logic signed [W-1:0] t_q;
    typedef logic signed [W:0]   t_sum;

    typedef struct packed {
        logic [1:0] func;
        t_q sx, sy, sz, cz;
        t_q cycz, cysz, sxsy, cxsz, cxcz, sxcy, cxsy, sxsz, cxcy, sycz, sysz, sxcz;
    } t_s2;

    typedef struct packed {
        t_s2 b;
        t_q  sxsy_cz, sxsy_sz, cxsy_cz, cxsy_sz, sxcy_sz, sxcy_cz;
    } t_s3;

    localparam logic [2*W-1:0] PROD_HALF = (2*W)'(1) << (FRAC_BITS - 1);
    localparam logic [AW-1:0]  QTOP      = AW'(QSIZE);
    localparam t_q             Q_ONE     = W'(ONE);
    localparam t_sum           SUM_ONE   = (W+1)'(ONE);

    function automatic t_q f_mulq(input t_q a, input t_q b);
        logic signed [2*W-1:0] p;
        logic [2*W-1:0]        mag;
        logic [2*W-1:0]        rnd;
        p   = a * b;
        mag = p[2*W-1] ? $unsigned(-p) : $unsigned(p);
        rnd = (mag + PROD_HALF) >> FRAC_BITS;
        return p[2*W-1] ? -t_q'(rnd[W-1:0]) : t_q'(rnd[W-1:0]);
    endfunction

    function automatic t_sum f_add(input t_q a, input t_q b);
        return t_sum'({a[W-1], a}) + t_sum'({b[W-1], b});
    endfunction

    function automatic t_q f_sat(input t_sum v);
        t_q res;
        if (v > SUM_ONE) begin
            res = Q_ONE;
        end else if (v < -SUM_ONE) begin
            res = -Q_ONE;
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    // Stage enables: a stage loads when it is empty or its content moves on.
    logic w_en1, w_en2, w_en3, w_en4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign w_en4 = !r_v4 || o_mat.ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_req.ready = w_en1;

    // Stage 1: angle folding and ROM lookup.
    logic [ANGLE_BITS-1:0] w_ang [3];
    logic [AW-1:0]         w_addr_s [3];
    logic [AW-1:0]         w_addr_c [3];
    logic [2:0]            n_neg_s, n_neg_c;
    logic [2:0]            r_neg_s, r_neg_c;
    logic [1:0]            r_f1;
    logic [FRAC_BITS:0]    w_mag_s [3];
    logic [FRAC_BITS:0]    w_mag_c [3];

    assign w_ang[0] = i_req.angle_x;
    assign w_ang[1] = i_req.angle_y;
    assign w_ang[2] = i_req.angle_z;

    always_comb begin
        logic [ANGLE_BITS-1:0] a;
        logic [1:0]            qs;
        logic [1:0]            qc;
        logic [AW-1:0]         r;
        for (int i = 0; i < 3; i++) begin
            a  = (i_req.func == eulrot_pkg::FUNC_ZXY_NEG) ? -w_ang[i] : w_ang[i];
            qs = a[ANGLE_BITS-1:ANGLE_BITS-2];
            qc = qs + 2'd1;
            r  = {1'b0, a[ANGLE_BITS-3:0]};
            w_addr_s[i] = qs[0] ? QTOP - r : r;
            w_addr_c[i] = qc[0] ? QTOP - r : r;
            n_neg_s[i]  = qs[1];
            n_neg_c[i]  = qc[1];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_rom
        eulrot_sin_rom #(
            .ANGLE_BITS(ANGLE_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_rom (
            .i_clk   (i_clk),
            .i_en    (w_en1),
            .i_addr_a(w_addr_s[g]),
            .i_addr_b(w_addr_c[g]),
            .o_data_a(w_mag_s[g]),
            .o_data_b(w_mag_c[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_neg_s <= n_neg_s;
            r_neg_c <= n_neg_c;
            r_f1    <= i_req.func;
        end
    end

    // Stage 2: signed sines and cosines, pairwise products.
    t_q  w_s [3];
    t_q  w_c [3];
    t_s2 n_s2, r_s2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s[i] = r_neg_s[i] ? -$signed({1'b0, w_mag_s[i]}) : $signed({1'b0, w_mag_s[i]});
            w_c[i] = r_neg_c[i] ? -$signed({1'b0, w_mag_c[i]}) : $signed({1'b0, w_mag_c[i]});
        end
        n_s2.func = r_f1;
        n_s2.sx   = w_s[0];
        n_s2.sy   = w_s[1];
        n_s2.sz   = w_s[2];
        n_s2.cz   = w_c[2];
        n_s2.cycz = f_mulq(w_c[1], w_c[2]);
        n_s2.cysz = f_mulq(w_c[1], w_s[2]);
        n_s2.sxsy = f_mulq(w_s[0], w_s[1]);
        n_s2.cxsz = f_mulq(w_c[0], w_s[2]);
        n_s2.cxcz = f_mulq(w_c[0], w_c[2]);
        n_s2.sxcy = f_mulq(w_s[0], w_c[1]);
        n_s2.cxsy = f_mulq(w_c[0], w_s[1]);
        n_s2.sxsz = f_mulq(w_s[0], w_s[2]);
        n_s2.cxcy = f_mulq(w_c[0], w_c[1]);
        n_s2.sycz = f_mulq(w_s[1], w_c[2]);
        n_s2.sysz = f_mulq(w_s[1], w_s[2]);
        n_s2.sxcz = f_mulq(w_s[0], w_c[2]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2 <= n_s2;
        end
    end

    // Stage 3: triple products.
    t_s3 n_s3, r_s3;

    always_comb begin
        n_s3.b       = r_s2;
        n_s3.sxsy_cz = f_mulq(r_s2.sxsy, r_s2.cz);
        n_s3.sxsy_sz = f_mulq(r_s2.sxsy, r_s2.sz);
        n_s3.cxsy_cz = f_mulq(r_s2.cxsy, r_s2.cz);
        n_s3.cxsy_sz = f_mulq(r_s2.cxsy, r_s2.sz);
        n_s3.sxcy_sz = f_mulq(r_s2.sxcy, r_s2.sz);
        n_s3.sxcy_cz = f_mulq(r_s2.sxcy, r_s2.cz);
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3 <= n_s3;
        end
    end

    // Stage 4: sums per mode and saturation.
    t_sum       w_sum [9];
    t_q         n_m [9];
    t_q         r_m [9];
    logic [1:0] r_f4;
    t_q         w_zero;

    assign w_zero = '0;

    always_comb begin
        case (r_s3.b.func)
            eulrot_pkg::FUNC_XYZ: begin
                w_sum[0] = f_add(r_s3.b.cycz, w_zero);
                w_sum[1] = f_add(-r_s3.b.cysz, w_zero);
                w_sum[2] = f_add(r_s3.b.sy, w_zero);
                w_sum[3] = f_add(r_s3.sxsy_cz, r_s3.b.cxsz);
                w_sum[4] = f_add(-r_s3.sxsy_sz, r_s3.b.cxcz);
                w_sum[5] = f_add(-r_s3.b.sxcy, w_zero);
                w_sum[6] = f_add(-r_s3.cxsy_cz, r_s3.b.sxsz);
                w_sum[7] = f_add(r_s3.cxsy_sz, r_s3.b.sxcz);
                w_sum[8] = f_add(r_s3.b.cxcy, w_zero);
            end
            eulrot_pkg::FUNC_Z_ONLY: begin
                w_sum[0] = f_add(r_s3.b.cz, w_zero);
                w_sum[1] = f_add(-r_s3.b.sz, w_zero);
                w_sum[2] = f_add(w_zero, w_zero);
                w_sum[3] = f_add(r_s3.b.sz, w_zero);
                w_sum[4] = f_add(r_s3.b.cz, w_zero);
                w_sum[5] = f_add(w_zero, w_zero);
                w_sum[6] = f_add(w_zero, w_zero);
                w_sum[7] = f_add(w_zero, w_zero);
                w_sum[8] = f_add(Q_ONE, w_zero);
            end
            default: begin
                w_sum[0] = f_add(r_s3.b.cycz, r_s3.sxsy_sz);
                w_sum[1] = f_add(r_s3.b.cxsz, w_zero);
                w_sum[2] = f_add(-r_s3.b.sycz, r_s3.sxcy_sz);
                w_sum[3] = f_add(-r_s3.b.cysz, r_s3.sxsy_cz);
                w_sum[4] = f_add(r_s3.b.cxcz, w_zero);
                w_sum[5] = f_add(r_s3.b.sysz, r_s3.sxcy_cz);
                w_sum[6] = f_add(r_s3.b.cxsy, w_zero);
                w_sum[7] = f_add(-r_s3.b.sx, w_zero);
                w_sum[8] = f_add(r_s3.b.cxcy, w_zero);
            end
        endcase
        for (int i = 0; i < 9; i++) begin
            n_m[i] = f_sat(w_sum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_m  <= n_m;
            r_f4 <= r_s3.b.func;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_req.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign o_mat.valid = r_v4;
    assign o_mat.m00   = r_m[0];
    assign o_mat.m01   = r_m[1];
    assign o_mat.m02   = r_m[2];
    assign o_mat.m10   = r_m[3];
    assign o_mat.m11   = r_m[4];
    assign o_mat.m12   = r_m[5];
    assign o_mat.m20   = r_m[6];
    assign o_mat.m21   = r_m[7];
    assign o_mat.m22   = r_m[8];

    a_z_only_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_f4 == eulrot_pkg::FUNC_Z_ONLY |-> r_m[8] == Q_ONE && r_m[2] == w_zero
            && r_m[6] == w_zero)
        else $error("z-only matrix has a wrong fixed entry");

    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> r_m[0] <= Q_ONE && r_m[0] >= -Q_ONE && r_m[4] <= Q_ONE && r_m[4] >= -Q_ONE)
        else $error("matrix entry outside the saturation range");

    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !w_en4 |=> r_v3 && $stable(r_s3))
        else $error("stalled stage 3 request was lost or changed");
endmodule

[sv/eulrot_sin_rom.sv]
// Quarter-wave sine ROM with two registered read ports.
module eulrot_sin_rom #(
    parameter int ANGLE_BITS = eulrot_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = eulrot_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-2:0] i_addr_a,
    input  logic [ANGLE_BITS-2:0] i_addr_b,
    output logic [FRAC_BITS:0]    o_data_a,
    output logic [FRAC_BITS:0]    o_data_b
);
    localparam int QSIZE = 1 << (ANGLE_BITS - 2);

    typedef logic [FRAC_BITS:0] t_tab [QSIZE+1];

    function automatic t_tab f_build();
        t_tab            tab;
        longint unsigned v;
        for (int k = 0; k <= QSIZE; k++) begin
            v = eulrot_pkg::f_quarter_sine($unsigned(64'(k)), ANGLE_BITS, FRAC_BITS);
            tab[k] = v[FRAC_BITS:0];
        end
        return tab;
    endfunction

    localparam t_tab TAB = f_build();

    logic [FRAC_BITS:0] r_data_a;
    logic [FRAC_BITS:0] r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= TAB[i_addr_a];
            r_data_b <= TAB[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;
endmodule

[tb/testbench.sv]
// Self-checking testbench for the Euler-angle rotation matrix generator.
`timescale 1ns / 1ps

module testbench;

    localparam int AB = eulrot_pkg::ANGLE_BITS_DEF;
    localparam int FB = eulrot_pkg::FRAC_BITS_DEF;
    localparam int QTR = 1 << (AB - 2);
    localparam longint ONE_Q12 = longint'(1) << FB;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int SERIES_TERMS = 12;
    localparam int PIPE_LATENCY = 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [FB+1:0] t_q12;
    typedef t_q12 [8:0] t_rot_matrix;

    logic i_clk;
    logic i_rst_n;

    eulrot_in_if  req_if ();
    eulrot_out_if mat_if ();

    euler_rotation_matrix_q12 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_mat   (mat_if.source)
    );

    longint      sine_q [0:QTR];
    t_rot_matrix expected_mats [$];
    int          error_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          cycle_count = 0;
    int          hold_request = 0;
    int          hold_left = 0;
    bit          steady_tx = 1'b0;
    bit          steady_rx = 1'b0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint quarter_wave_entry(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned den;
        longint          acc;
        int              n;
        x    = (QUARTER_TURN_Q30 * k + QTR / 2) / QTR;
        x2   = (x * x) >> 30;
        term = x;
        acc  = $signed(x);
        for (n = 1; n <= SERIES_TERMS; n++) begin
            den  = longint'(2 * n) * longint'(2 * n + 1);
            term = ((term * x2) >> 30) / den;
            if (n % 2 == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + (longint'(1) << (29 - FB))) >>> (30 - FB);
        if (acc > ONE_Q12) begin
            acc = ONE_Q12;
        end
        return acc;
    endfunction

    function automatic longint sin_lookup(input logic [AB-1:0] a);
        int     r;
        longint v;
        r = int'(a[AB-3:0]);
        v = a[AB-2] ? sine_q[QTR - r] : sine_q[r];
        return a[AB-1] ? -v : v;
    endfunction

    function automatic longint cos_lookup(input logic [AB-1:0] a);
        logic [AB-1:0] b;
        b = a + AB'(QTR);
        return sin_lookup(b);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        longint p;
        longint mag;
        p   = a * b;
        mag = (p < 0) ? -p : p;
        mag = (mag + (longint'(1) << (FB - 1))) >>> FB;
        return (p < 0) ? -mag : mag;
    endfunction

    function automatic t_q12 clamp_q12(input longint v);
        if (v > ONE_Q12) begin
            v = ONE_Q12;
        end
        if (v < -ONE_Q12) begin
            v = -ONE_Q12;
        end
        return t_q12'(v);
    endfunction

    function automatic t_rot_matrix predict_rotation(input logic [1:0] fn,
                                                     input logic [AB-1:0] ax,
                                                     input logic [AB-1:0] ay,
                                                     input logic [AB-1:0] az);
        longint      sx, cx, sy, cy, sz, cz;
        longint      e [9];
        t_rot_matrix res;
        if (fn == eulrot_pkg::FUNC_ZXY_NEG) begin
            ax = -ax;
            ay = -ay;
            az = -az;
        end
        sx = sin_lookup(ax);
        cx = cos_lookup(ax);
        sy = sin_lookup(ay);
        cy = cos_lookup(ay);
        sz = sin_lookup(az);
        cz = cos_lookup(az);
        if (fn == eulrot_pkg::FUNC_XYZ) begin
            e[0] = qmul(cy, cz);
            e[1] = -qmul(cy, sz);
            e[2] = sy;
            e[3] = qmul(qmul(sx, sy), cz) + qmul(cx, sz);
            e[4] = -qmul(qmul(sx, sy), sz) + qmul(cx, cz);
            e[5] = -qmul(sx, cy);
            e[6] = -qmul(qmul(cx, sy), cz) + qmul(sx, sz);
            e[7] = qmul(qmul(cx, sy), sz) + qmul(sx, cz);
            e[8] = qmul(cx, cy);
        end else if (fn == eulrot_pkg::FUNC_Z_ONLY) begin
            e[0] = cz;
            e[1] = -sz;
            e[2] = 0;
            e[3] = sz;
            e[4] = cz;
            e[5] = 0;
            e[6] = 0;
            e[7] = 0;
            e[8] = ONE_Q12;
        end else begin
            e[0] = qmul(cy, cz) + qmul(qmul(sy, sx), sz);
            e[1] = qmul(cx, sz);
            e[2] = -qmul(sy, cz) + qmul(qmul(cy, sx), sz);
            e[3] = -qmul(cy, sz) + qmul(qmul(sy, sx), cz);
            e[4] = qmul(cx, cz);
            e[5] = qmul(sy, sz) + qmul(qmul(cy, sx), cz);
            e[6] = qmul(sy, cx);
            e[7] = -sx;
            e[8] = qmul(cy, cx);
        end
        for (int i = 0; i < 9; i++) begin
            res[i] = clamp_q12(e[i]);
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [AB-1:0] random_angle();
        int q;
        if ($urandom_range(0, 3) == 0) begin
            q = $urandom_range(0, 3);
            return AB'(q * QTR + $urandom_range(0, 6) - 3);
        end
        return AB'($urandom_range(0, (1 << AB) - 1));
    endfunction

    // Must be entered just after a falling edge; returns just after a falling edge.
    task automatic send_request(input logic [1:0] fn, input logic [AB-1:0] ax,
                                input logic [AB-1:0] ay, input logic [AB-1:0] az);
        int gap;
        gap = steady_tx ? 0 : pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.func    <= fn;
        req_if.angle_x <= ax;
        req_if.angle_y <= ay;
        req_if.angle_z <= az;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        expected_mats.push_back(predict_rotation(fn, ax, ay, az));
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_mats.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic test_directed_cases();
        logic [1:0] modes [4];
        modes = '{eulrot_pkg::FUNC_ZXY_NEG, eulrot_pkg::FUNC_XYZ, eulrot_pkg::FUNC_ZXY,
                  eulrot_pkg::FUNC_Z_ONLY};
        foreach (modes[i]) begin
            send_request(modes[i], '0, '0, '0);
            send_request(modes[i], '1, '1, '1);
        end
        send_request(eulrot_pkg::FUNC_XYZ, 12'd1024, 12'd2048, 12'd3072);
        send_request(eulrot_pkg::FUNC_ZXY, 12'd3072, 12'd1024, 12'd2048);
        send_request(eulrot_pkg::FUNC_ZXY_NEG, 12'd2048, 12'd3072, 12'd1024);
        send_request(eulrot_pkg::FUNC_XYZ, 12'd512, 12'd512, 12'd512);
        send_request(eulrot_pkg::FUNC_ZXY, 12'd512, 12'd3584, 12'd512);
        send_request(eulrot_pkg::FUNC_ZXY_NEG, 12'd1, 12'd1023, 12'd1025);
        send_request(eulrot_pkg::FUNC_Z_ONLY, 12'd4095, 12'd0, 12'd1024);
        send_request(eulrot_pkg::FUNC_Z_ONLY, 12'd0, 12'd4095, 12'd2048);
        send_request(eulrot_pkg::FUNC_Z_ONLY, 12'd1234, 12'd2345, 12'd3072);
        send_request(eulrot_pkg::FUNC_XYZ, 12'd2047, 12'd2049, 12'd3071);
        send_request(eulrot_pkg::FUNC_ZXY, 12'd1, 12'd4095, 12'd2048);
        wait_drained();
    endtask

    task automatic test_random_requests(input int count);
        for (int i = 0; i < count; i++) begin
            send_request(2'($urandom_range(0, 3)), random_angle(), random_angle(),
                         random_angle());
        end
        wait_drained();
    endtask

    task automatic test_back_to_back(input int count);
        steady_tx = 1'b1;
        steady_rx = 1'b1;
        test_random_requests(count);
        steady_tx = 1'b0;
        steady_rx = 1'b0;
    endtask

    task automatic test_output_backpressure(input int count);
        steady_tx = 1'b1;
        hold_request = 60;
        test_random_requests(count);
        steady_tx = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.func    = eulrot_pkg::FUNC_ZXY_NEG;
        req_if.angle_x = '0;
        req_if.angle_y = '0;
        req_if.angle_z = '0;
        for (int k = 0; k <= QTR; k++) begin
            sine_q[k] = quarter_wave_entry(longint'(k));
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_cases();
        test_random_requests(400);
        test_back_to_back(200);
        test_output_backpressure(48);
        test_random_requests(300);
        $display("Sent %0d requests and checked %0d matrices across all four modes.",
                 sent_count, checked_count);
        $display("Traffic mixed random gaps, back-to-back bursts and a long output stall.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        mat_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                mat_if.ready <= 1'b0;
                hold_left--;
            end else begin
                mat_if.ready <= 1'b1;
                if (!steady_rx) begin
                    hold_left = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_rot_matrix got;
        t_rot_matrix want;
        if (i_rst_n && mat_if.valid && mat_if.ready) begin
            got = {mat_if.m22, mat_if.m21, mat_if.m20, mat_if.m12, mat_if.m11,
                   mat_if.m10, mat_if.m02, mat_if.m01, mat_if.m00};
            if (expected_mats.size() == 0) begin
                $display("%0t: unexpected matrix, expected none, got m00 %0d", $time,
                         $signed(got[0]));
                error_count++;
            end else begin
                want = expected_mats.pop_front();
                checked_count++;
                for (int i = 0; i < 9; i++) begin
                    if (got[i] !== want[i]) begin
                        $display("%0t: m%0d%0d mismatch, expected %0d, got %0d", $time,
                                 i / 3, i % 3, $signed(want[i]), $signed(got[i]));
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d matrices outstanding", $time,
                     expected_mats.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

[filelist.f]
sv/eulrot_pkg.sv
sv/eulrot_in_if.sv
sv/eulrot_out_if.sv
sv/eulrot_sin_rom.sv
sv/euler_rotation_matrix_q12.sv
tb/testbench.sv
